// ===== sv/srcp_pkg.sv =====
// Shared types, character codes and helpers for the serial register command parser.
`default_nettype none
package srcp_pkg;

   localparam int CharWidth   = 8;
   localparam int KindWidth   = 2;
   localparam int BusWidth    = 7;
   localparam int AddrWidth   = 8;
   localparam int DataWidth   = 8;
   localparam int RegIdxWidth = 4;
   localparam int NibWidth    = 4;
   localparam int CsrIdxWidth = 1;
   localparam int CsrDatWidth = 8;

   localparam logic [CsrIdxWidth-1:0] CSR_REG_BASE = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_BUS_ADDR = 1'd1;

   localparam logic [KindWidth-1:0] KIND_NONE  = 2'd0;
   localparam logic [KindWidth-1:0] KIND_WRITE = 2'd1;
   localparam logic [KindWidth-1:0] KIND_PAGE  = 2'd2;

   localparam logic [CharWidth-1:0] CH_CR     = 8'h0D;
   localparam logic [CharWidth-1:0] CH_EQ     = 8'h3D;
   localparam logic [CharWidth-1:0] CH_ZERO   = 8'h30;
   localparam logic [CharWidth-1:0] CH_ONE    = 8'h31;
   localparam logic [CharWidth-1:0] CH_NINE   = 8'h39;
   localparam logic [CharWidth-1:0] CH_UP_A   = 8'h41;
   localparam logic [CharWidth-1:0] CH_UP_C   = 8'h43;
   localparam logic [CharWidth-1:0] CH_UP_F   = 8'h46;
   localparam logic [CharWidth-1:0] CH_UP_P   = 8'h50;
   localparam logic [CharWidth-1:0] CH_LO_A   = 8'h61;
   localparam logic [CharWidth-1:0] CH_LO_C   = 8'h63;
   localparam logic [CharWidth-1:0] CH_LO_F   = 8'h66;
   localparam logic [CharWidth-1:0] CH_LO_P   = 8'h70;
   localparam logic [CharWidth-1:0] HEX_TEN   = 8'd10;

   typedef struct packed {
      logic [KindWidth-1:0]   event_kind;
      logic [BusWidth-1:0]    target_bus_address;
      logic [AddrWidth-1:0]   device_reg_address;
      logic [DataWidth-1:0]   write_data;
      logic [RegIdxWidth-1:0] register_index;
      logic                   page_now;
   } result_type;

   typedef struct packed {
      logic                valid;
      logic [NibWidth-1:0] value;
   } nibble_type;

   function automatic nibble_type nibble_of(input logic [CharWidth-1:0] ch);
      nibble_type              n;
      logic [CharWidth-1:0]    diff;
      n    = '{valid: 1'b0, value: '0};
      diff = '0;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         diff = ch - CH_ZERO;
         n    = '{valid: 1'b1, value: diff[NibWidth-1:0]};
      end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
         diff = ch - CH_UP_A + HEX_TEN;
         n    = '{valid: 1'b1, value: diff[NibWidth-1:0]};
      end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
         diff = ch - CH_LO_A + HEX_TEN;
         n    = '{valid: 1'b1, value: diff[NibWidth-1:0]};
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ===== sv/serial_register_command_parser_unit.sv =====
// Top level of the serial register command parser: byte parser, shadow store and result skid.
//
// Usage: feed one ASCII character per item on the req_ channel (req_valid,
// req_stall, req_char_byte). Every accepted item yields exactly one result
// item on the rsp_ channel: the event kind, the bus write fields (zero when
// no write is issued) and the current page flag.
// Commands: "C<d>=<h><h><CR>" stores a byte in shadow register d and issues
// a write to register_base_address + d - 1; "P<CR>" toggles the page.
// Any out-of-order character drops the parser back to idle.
// The result is registered in the result register, or in the skid register while stalled.
// Throughput: one item per cycle while req_stall is low.
// Stall: a two-entry output (result register plus skid register) keeps the
// input open while one result waits; req_stall rises only once the skid
// register is full, and falls the cycle after the receiver takes a result.
// Configuration: csr_write with csr_index 0 (register base address) or 1
// (bus device address); the user writes it only while the block is idle (not enforced).
// Reset: synchronous, active high; parser idle, page 0, shadow store cleared,
// configuration zero, no result pending.
`default_nettype none
module serial_register_command_parser_unit #(
   parameter int NUM_SHADOW_REGS = 9
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [srcp_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [srcp_pkg::CsrDatWidth-1:0]    csr_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [srcp_pkg::CharWidth-1:0]      req_char_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [srcp_pkg::KindWidth-1:0]           rsp_event_kind,
   output logic [srcp_pkg::BusWidth-1:0]            rsp_target_bus_address,
   output logic [srcp_pkg::AddrWidth-1:0]           rsp_device_reg_address,
   output logic [srcp_pkg::DataWidth-1:0]           rsp_write_data,
   output logic [srcp_pkg::RegIdxWidth-1:0]         rsp_register_index,
   output logic                                     rsp_page_now
);
   import srcp_pkg::*;

   localparam int ShadowIdxWidth = (NUM_SHADOW_REGS > 1) ? $clog2(NUM_SHADOW_REGS) : 1;
   localparam logic [CharWidth-1:0] MaxDigit = CH_ZERO + CharWidth'(NUM_SHADOW_REGS);
   localparam logic [RegIdxWidth-1:0] MaxReg = RegIdxWidth'(NUM_SHADOW_REGS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMD,
      ST_REG,
      ST_EQ,
      ST_HI,
      ST_LO,
      ST_PAGE
   } parse_state_type;

   parse_state_type           parse_state_ff, parse_state_in;
   logic [RegIdxWidth-1:0]    pending_register_ff, pending_register_in;
   logic [DataWidth-1:0]      value_accumulator_ff, value_accumulator_in;
   logic                      page_flag_ff, page_flag_in;
   logic [DataWidth-1:0]      shadow_ff [NUM_SHADOW_REGS];
   logic [AddrWidth-1:0]      reg_base_ff;
   logic [BusWidth-1:0]       bus_addr_ff;
   result_type                out_ff, skid_ff, result_in;
   logic                      out_valid_ff, skid_valid_ff;

   logic                      accept;
   logic                      take;
   logic                      shadow_we;
   nibble_type                nib;
   logic [CharWidth-1:0]      digit;
   logic [RegIdxWidth-1:0]    reg_minus_one;
   logic [ShadowIdxWidth-1:0] shadow_idx;

   assign accept        = req_valid && !skid_valid_ff;
   assign take          = out_valid_ff && !rsp_stall;
   assign req_stall     = skid_valid_ff;
   assign nib           = nibble_of(req_char_byte);
   assign digit         = req_char_byte - CH_ZERO;
   assign reg_minus_one = pending_register_ff - RegIdxWidth'(1);
   assign shadow_idx    = reg_minus_one[ShadowIdxWidth-1:0];

   always_comb begin
      parse_state_in       = ST_IDLE;
      pending_register_in  = pending_register_ff;
      value_accumulator_in = value_accumulator_ff;
      page_flag_in         = page_flag_ff;
      shadow_we            = 1'b0;
      result_in            = '0;
      unique case (parse_state_ff)
         ST_IDLE: begin
            if (req_char_byte == CH_UP_C || req_char_byte == CH_LO_C) begin
               parse_state_in = ST_CMD;
            end else if (req_char_byte == CH_UP_P || req_char_byte == CH_LO_P) begin
               parse_state_in = ST_PAGE;
            end
         end
         ST_CMD: begin
            if (req_char_byte >= CH_ONE && req_char_byte <= MaxDigit) begin
               pending_register_in = digit[RegIdxWidth-1:0];
               parse_state_in      = ST_REG;
            end
         end
         ST_REG: begin
            if (req_char_byte == CH_EQ) begin
               parse_state_in = ST_EQ;
            end
         end
         ST_EQ: begin
            if (nib.valid) begin
               value_accumulator_in = {nib.value, {(DataWidth-NibWidth){1'b0}}};
               parse_state_in       = ST_HI;
            end
         end
         ST_HI: begin
            if (nib.valid) begin
               value_accumulator_in = value_accumulator_ff
                                    | {{(DataWidth-NibWidth){1'b0}}, nib.value};
               parse_state_in       = ST_LO;
            end
         end
         ST_LO: begin
            if (req_char_byte == CH_CR && pending_register_ff != '0
                && pending_register_ff <= MaxReg) begin
               shadow_we                    = 1'b1;
               result_in.event_kind         = KIND_WRITE;
               result_in.target_bus_address = bus_addr_ff;
               result_in.device_reg_address = reg_base_ff
                  + {{(AddrWidth-RegIdxWidth){1'b0}}, pending_register_ff}
                  - AddrWidth'(1);
               result_in.write_data         = value_accumulator_ff;
               result_in.register_index     = pending_register_ff;
            end
         end
         ST_PAGE: begin
            if (req_char_byte == CH_CR) begin
               page_flag_in         = !page_flag_ff;
               result_in.event_kind = KIND_PAGE;
            end
         end
         default: begin
            parse_state_in = ST_IDLE;
         end
      endcase
      result_in.page_now = page_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_state_ff       <= ST_IDLE;
         pending_register_ff  <= '0;
         value_accumulator_ff <= '0;
         page_flag_ff         <= 1'b0;
         reg_base_ff          <= '0;
         bus_addr_ff          <= '0;
         out_valid_ff         <= 1'b0;
         skid_valid_ff        <= 1'b0;
         for (int i = 0; i < NUM_SHADOW_REGS; i++) begin
            shadow_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_REG_BASE: reg_base_ff <= csr_data[AddrWidth-1:0];
               CSR_BUS_ADDR: bus_addr_ff <= csr_data[BusWidth-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            parse_state_ff       <= parse_state_in;
            pending_register_ff  <= pending_register_in;
            value_accumulator_ff <= value_accumulator_in;
            page_flag_ff         <= page_flag_in;
            if (shadow_we) begin
               shadow_ff[shadow_idx] <= value_accumulator_ff;
            end
         end
         // hold the result while stalled; park a new item in the skid register
         if (out_valid_ff && !take) begin
            if (accept) begin
               skid_ff       <= result_in;
               skid_valid_ff <= 1'b1;
            end
         end else if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_ff       <= result_in;
            out_valid_ff <= accept;
         end
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_event_kind         = out_ff.event_kind;
   assign rsp_target_bus_address = out_ff.target_bus_address;
   assign rsp_device_reg_address = out_ff.device_reg_address;
   assign rsp_write_data         = out_ff.write_data;
   assign rsp_register_index     = out_ff.register_index;
   assign rsp_page_now           = out_ff.page_now;

endmodule
`default_nettype wire
